@@ hw/rtl/u8dw_pkg.sv @@
package u8dw_pkg;

  localparam int unsigned SumBits = 16;
  localparam int unsigned CpBits  = 21;
  localparam int unsigned OutBits = 16;

  // Lead byte class boundaries.
  localparam logic [7:0] LeadTwo   = 8'h80;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;

  // Display width codes.
  localparam logic [1:0] ColsNone   = 2'd0;
  localparam logic [1:0] ColsNarrow = 2'd1;
  localparam logic [1:0] ColsWide   = 2'd2;

  typedef logic [CpBits-1:0] cp_t;

  // One word handed from the decoder to the accumulator.
  typedef struct packed {
    logic       cp_valid;
    cp_t        cp;
    logic [2:0] len;
    logic       eos;
    logic       trunc;
  } evt_t;

  function automatic logic wide_char(cp_t c);
    logic w;
    w = (c >= 21'h01100 && c <= 21'h0115F)
     || (c == 21'h02329) || (c == 21'h0232A)
     || (c >= 21'h02E80 && c <= 21'h0A4CF && c != 21'h0303F)
     || (c >= 21'h0AC00 && c <= 21'h0D7A3)
     || (c >= 21'h0F900 && c <= 21'h0FAFF)
     || (c >= 21'h0FE10 && c <= 21'h0FE19)
     || (c >= 21'h0FE30 && c <= 21'h0FE6F)
     || (c >= 21'h0FF00 && c <= 21'h0FF60)
     || (c >= 21'h0FFE0 && c <= 21'h0FFE6)
     || (c >= 21'h20000 && c <= 21'h2FFFD)
     || (c >= 21'h30000 && c <= 21'h3FFFD);
    return w;
  endfunction

  function automatic logic [1:0] char_cols(cp_t c);
    logic [1:0] r;
    if (c == '0) begin
      r = ColsNone;
    end else if (wide_char(c)) begin
      r = ColsWide;
    end else begin
      r = ColsNarrow;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/u8dw_front.sv @@
module u8dw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_string_i,
  output logic            evt_valid_o,
  input  logic            evt_ready_i,
  output u8dw_pkg::evt_t  evt_o
);
  import u8dw_pkg::*;

  logic [1:0] rem_q, rem_d, rem_n;
  logic [2:0] len_q, len_d, len_n;
  cp_t        part_q, part_d, part_n;
  logic       done;
  logic       accept;

  always_comb begin
    if (rem_q == 2'd0) begin
      if (data_byte_i < LeadTwo) begin
        len_n  = 3'd1;
        part_n = CpBits'(data_byte_i);
      end else if (data_byte_i < LeadThree) begin
        len_n  = 3'd2;
        part_n = CpBits'(data_byte_i[4:0]);
      end else if (data_byte_i < LeadFour) begin
        len_n  = 3'd3;
        part_n = CpBits'(data_byte_i[3:0]);
      end else begin
        len_n  = 3'd4;
        part_n = CpBits'(data_byte_i[2:0]);
      end
      rem_n = 2'(len_n - 3'd1);
    end else begin
      len_n  = len_q;
      part_n = {part_q[CpBits-7:0], data_byte_i[5:0]};
      rem_n  = rem_q - 2'd1;
    end
  end

  assign done       = (rem_n == 2'd0);
  assign in_ready_o = evt_ready_i;
  assign accept     = in_valid_i && evt_ready_i;

  // A word goes to the queue only when a codepoint completes or the string ends.
  assign evt_valid_o    = in_valid_i && (done || end_of_string_i);
  assign evt_o.cp_valid = done;
  assign evt_o.cp       = done ? part_n : '0;
  assign evt_o.len      = done ? len_n : 3'd0;
  assign evt_o.eos      = end_of_string_i;
  assign evt_o.trunc    = end_of_string_i && !done;

  always_comb begin
    rem_d  = rem_q;
    len_d  = len_q;
    part_d = part_q;
    if (accept) begin
      if (end_of_string_i || done) begin
        rem_d  = 2'd0;
        len_d  = 3'd0;
        part_d = '0;
      end else begin
        rem_d  = rem_n;
        len_d  = len_n;
        part_d = part_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      len_q  <= 3'd0;
      part_q <= '0;
    end else begin
      rem_q  <= rem_d;
      len_q  <= len_d;
      part_q <= part_d;
    end
  end

endmodule

@@ hw/rtl/u8dw_fifo.sv @@
module u8dw_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u8dw_pkg::evt_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output u8dw_pkg::evt_t  pop_data_o
);
  import u8dw_pkg::*;

  evt_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hw/rtl/u8dw_back.sv @@
module u8dw_back #(
  parameter int unsigned SUM_BITS = u8dw_pkg::SumBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  u8dw_pkg::evt_t                 evt_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           codepoint_valid_o,
  output logic [u8dw_pkg::CpBits-1:0]    codepoint_o,
  output logic [2:0]                     byte_count_o,
  output logic [1:0]                     char_width_o,
  output logic                           string_done_o,
  output logic [u8dw_pkg::OutBits-1:0]   total_width_o,
  output logic [u8dw_pkg::OutBits-1:0]   padding_total_o,
  output logic                           truncated_o
);
  import u8dw_pkg::*;

  logic [SUM_BITS-1:0] wsum_q, wsum_d, psum_q, psum_d;
  logic [SUM_BITS-1:0] wsum_n, psum_n;
  logic [SUM_BITS:0]   wadd, padd;
  logic [1:0]          cols;
  logic [2:0]          pad_amt;
  logic                out_valid_q;

  logic                cpv_q, done_q, trunc_q;
  cp_t                 cp_q;
  logic [2:0]          len_q;
  logic [1:0]          cols_q;
  logic [OutBits-1:0]  tw_q, pt_q;

  // The output register is free when empty or being taken this cycle.
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  assign cols    = evt_i.cp_valid ? char_cols(evt_i.cp) : ColsNone;
  assign pad_amt = evt_i.len - 3'(cols);

  always_comb begin
    wadd = {1'b0, wsum_q} + (SUM_BITS+1)'(cols);
    padd = {1'b0, psum_q} + (SUM_BITS+1)'(pad_amt);
    wsum_n = wadd[SUM_BITS] ? '1 : wadd[SUM_BITS-1:0];
    if (evt_i.cp_valid && evt_i.cp != '0) begin
      psum_n = padd[SUM_BITS] ? '1 : padd[SUM_BITS-1:0];
    end else begin
      psum_n = psum_q;
    end
    wsum_d = wsum_q;
    psum_d = psum_q;
    if (pop_o) begin
      wsum_d = evt_i.eos ? '0 : wsum_n;
      psum_d = evt_i.eos ? '0 : psum_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsum_q      <= '0;
      psum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wsum_q <= wsum_d;
      psum_q <= psum_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cpv_q   <= evt_i.cp_valid;
      cp_q    <= evt_i.cp;
      len_q   <= evt_i.len;
      cols_q  <= cols;
      done_q  <= evt_i.eos;
      trunc_q <= evt_i.trunc;
      tw_q    <= evt_i.eos ? OutBits'(wsum_n) : '0;
      pt_q    <= evt_i.eos ? OutBits'(psum_n) : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign codepoint_valid_o = cpv_q;
  assign codepoint_o       = cp_q;
  assign byte_count_o      = len_q;
  assign char_width_o      = cols_q;
  assign string_done_o     = done_q;
  assign total_width_o     = tw_q;
  assign padding_total_o   = pt_q;
  assign truncated_o       = trunc_q;

endmodule

@@ hw/rtl/utf8_display_width_meter_top.sv @@
// UTF-8 display width meter.
// The input channel takes one byte of a UTF-8 string per word, with
// end_of_string_i marking the last byte. The output channel gives one word
// for each completed codepoint (value, byte count, display columns) and one
// on the final byte carrying the string totals and the truncation flag;
// both can share a single word. Bytes that complete nothing give no word.
// A byte is accepted every cycle while the queue is not full. The decoder
// pushes its word into a two-entry queue at the accepting edge, and the
// accumulator moves it into the output register once that register is
// free. Sustained rate is one byte per clock while the receiver is ready.
// If the receiver stalls, the output register holds its word and the queue
// absorbs the following ones; input ready falls once the queue is full.
// Reset clears the decoder state, the queue and both running sums; the
// block then waits for the lead byte of a new string.
module utf8_display_width_meter_top #(
  parameter int unsigned SUM_BITS = u8dw_pkg::SumBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_string_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          codepoint_valid_o,
  output logic [u8dw_pkg::CpBits-1:0]   codepoint_o,
  output logic [2:0]                    byte_count_o,
  output logic [1:0]                    char_width_o,
  output logic                          string_done_o,
  output logic [u8dw_pkg::OutBits-1:0]  total_width_o,
  output logic [u8dw_pkg::OutBits-1:0]  padding_total_o,
  output logic                          truncated_o
);
  import u8dw_pkg::*;

  evt_t front_evt, back_evt;
  logic front_evt_valid, push, full, empty, pop;

  assign push = front_evt_valid && !full;

  u8dw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .evt_valid_o     (front_evt_valid),
    .evt_ready_i     (!full),
    .evt_o           (front_evt)
  );

  u8dw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_evt),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (back_evt)
  );

  u8dw_back #(
    .SUM_BITS (SUM_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .evt_i             (back_evt),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .codepoint_valid_o (codepoint_valid_o),
    .codepoint_o       (codepoint_o),
    .byte_count_o      (byte_count_o),
    .char_width_o      (char_width_o),
    .string_done_o     (string_done_o),
    .total_width_o     (total_width_o),
    .padding_total_o   (padding_total_o),
    .truncated_o       (truncated_o)
  );

  // Every word has a reason: a codepoint, the end of the string, or both.
  a_word_has_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (codepoint_valid_o || string_done_o))
    else $error("output word carries neither a codepoint nor string end");

  // A truncated string cannot also complete a codepoint on its final byte.
  a_trunc_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && truncated_o) |-> (string_done_o && !codepoint_valid_o))
    else $error("truncation flag on a word that is not a bare string end");

  // Byte count stays within the lead classes and NUL alone has no width.
  a_cp_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && codepoint_valid_o) |->
      (byte_count_o >= 3'd1 && byte_count_o <= 3'd4 &&
       ((char_width_o == ColsNone) == (codepoint_o == '0))))
    else $error("codepoint word has inconsistent byte count or width");

  // No word is lost: a full queue never sees the input accepted.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !in_ready_o)
    else $error("input accepted while the queue is full");

endmodule

@@ tb/testbench.sv @@
module testbench;
  import u8dw_pkg::*;

  localparam int NumSpans    = 12;
  localparam int DrainLimit  = 4000;
  localparam int RandomBytes = 600;
  localparam int PrintCap    = 40;

  typedef struct packed {
    logic               cp_valid;
    logic [CpBits-1:0]  cp;
    logic [2:0]         nbytes;
    logic [1:0]         cols;
    logic               done;
    logic [OutBits-1:0] width_tot;
    logic [OutBits-1:0] pad_tot;
    logic               trunc;
  } meter_word_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    meter_word_t word;
  } byte_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         byte_in;
  logic               last_in;
  logic               out_valid;
  logic               out_ready;
  logic               cp_valid;
  logic [CpBits-1:0]  cp;
  logic [2:0]         byte_count;
  logic [1:0]         char_width;
  logic               string_done;
  logic [OutBits-1:0] total_width;
  logic [OutBits-1:0] padding_total;
  logic               truncated;

  // Decoder and running sums as the block should hold them.
  logic [CpBits-1:0]  dec_acc;
  logic [1:0]         dec_left;
  logic [2:0]         dec_len;
  longint unsigned    col_sum;
  longint unsigned    pad_sum;

  meter_word_t        word_q[$];
  byte_row_t          tag_q[$];
  byte_row_t          dir_q[$];
  logic [7:0]         str_q[$];
  int                 errors = 0;
  int                 words_seen = 0;
  int                 bytes_sent = 0;
  logic               calm = 1'b0;

  utf8_display_width_meter_top #(
    .SUM_BITS(SumBits)
  ) DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (byte_in),
    .end_of_string_i   (last_in),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .codepoint_valid_o (cp_valid),
    .codepoint_o       (cp),
    .byte_count_o      (byte_count),
    .char_width_o      (char_width),
    .string_done_o     (string_done),
    .total_width_o     (total_width),
    .padding_total_o   (padding_total),
    .truncated_o       (truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL utf8_display_width_meter_top");
    $finish;
  end

  // East Asian wide spans; the gap at U+303F splits one span in two.
  function automatic void wide_span(input int k, output logic [CpBits-1:0] lo,
                                    output logic [CpBits-1:0] hi);
    case (k)
      0: begin lo = 21'h01100; hi = 21'h0115F; end
      1: begin lo = 21'h02329; hi = 21'h0232A; end
      2: begin lo = 21'h02E80; hi = 21'h0303E; end
      3: begin lo = 21'h03040; hi = 21'h0A4CF; end
      4: begin lo = 21'h0AC00; hi = 21'h0D7A3; end
      5: begin lo = 21'h0F900; hi = 21'h0FAFF; end
      6: begin lo = 21'h0FE10; hi = 21'h0FE19; end
      7: begin lo = 21'h0FE30; hi = 21'h0FE6F; end
      8: begin lo = 21'h0FF00; hi = 21'h0FF60; end
      9: begin lo = 21'h0FFE0; hi = 21'h0FFE6; end
      10: begin lo = 21'h20000; hi = 21'h2FFFD; end
      default: begin lo = 21'h30000; hi = 21'h3FFFD; end
    endcase
  endfunction

  function automatic logic [1:0] display_cols(input logic [CpBits-1:0] c);
    logic [CpBits-1:0] lo, hi;
    logic [1:0]        cols;
    cols = (c == '0) ? ColsNone : ColsNarrow;
    for (int k = 0; k < NumSpans; k++) begin
      wide_span(k, lo, hi);
      if (c >= lo && c <= hi) cols = ColsWide;
    end
    return cols;
  endfunction

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned top;
    top = (64'd1 << SumBits) - 64'd1;
    return (a + b > top) ? top : a + b;
  endfunction

  function automatic void meter_clear();
    dec_acc  = '0;
    dec_left = '0;
    dec_len  = '0;
    col_sum  = 0;
    pad_sum  = 0;
  endfunction

  function automatic void meter_step(input logic [7:0] b, input logic last,
                                     output logic emits, output meter_word_t w);
    logic fin;
    w   = '0;
    fin = 1'b0;
    if (dec_left == 2'd0) begin
      if (b < LeadTwo) begin
        dec_len = 3'd1;
        dec_acc = CpBits'(b);
      end else if (b < LeadThree) begin
        dec_len = 3'd2;
        dec_acc = CpBits'(b[4:0]);
      end else if (b < LeadFour) begin
        dec_len = 3'd3;
        dec_acc = CpBits'(b[3:0]);
      end else begin
        dec_len = 3'd4;
        dec_acc = CpBits'(b[2:0]);
      end
      dec_left = 2'(dec_len - 3'd1);
    end else begin
      dec_acc  = {dec_acc[CpBits-7:0], b[5:0]};
      dec_left = dec_left - 2'd1;
    end
    if (dec_left == 2'd0) begin
      fin        = 1'b1;
      w.cp_valid = 1'b1;
      w.cp       = dec_acc;
      w.nbytes   = dec_len;
      w.cols     = display_cols(dec_acc);
      col_sum    = sat_add(col_sum, 64'(w.cols));
      // NUL adds no padding.
      if (dec_acc != '0) pad_sum = sat_add(pad_sum, 64'(dec_len) - 64'(w.cols));
      dec_acc = '0;
      dec_len = '0;
    end
    emits = fin || last;
    if (last) begin
      w.done      = 1'b1;
      w.width_tot = OutBits'(col_sum);
      w.pad_tot   = OutBits'(pad_sum);
      w.trunc     = (dec_left != 2'd0);
      meter_clear();
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (errors <= PrintCap) begin
      $display("mismatch in %s at word %0d: got 0x%0h, expected 0x%0h",
               what, words_seen, got, want);
    end
  endtask

  task automatic compare_word(input meter_word_t got, input meter_word_t want);
    if (got.cp_valid !== want.cp_valid)
      report_mismatch("codepoint_valid", got.cp_valid, want.cp_valid);
    if (got.cp !== want.cp) report_mismatch("codepoint", got.cp, want.cp);
    if (got.nbytes !== want.nbytes) report_mismatch("byte_count", got.nbytes, want.nbytes);
    if (got.cols !== want.cols) report_mismatch("char_width", got.cols, want.cols);
    if (got.done !== want.done) report_mismatch("string_done", got.done, want.done);
    if (got.width_tot !== want.width_tot)
      report_mismatch("total_width", got.width_tot, want.width_tot);
    if (got.pad_tot !== want.pad_tot)
      report_mismatch("padding_total", got.pad_tot, want.pad_tot);
    if (got.trunc !== want.trunc) report_mismatch("truncated", got.trunc, want.trunc);
  endtask

  // Both handshakes are sampled here, so prediction and checking share one order.
  always @(posedge clk) begin : monitor
    meter_word_t w, got;
    byte_row_t   tag;
    logic        emits;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tag = tag_q.pop_front();
        meter_step(byte_in, last_in, emits, w);
        if (tag.typed) w = tag.word;
        if (emits) word_q.push_back(w);
      end
      if (out_valid && out_ready) begin
        words_seen++;
        got = {cp_valid, cp, byte_count, char_width, string_done, total_width,
               padding_total, truncated};
        if (word_q.size() == 0) begin
          report_mismatch("word with nothing expected", got.cp, 0);
        end else begin
          compare_word(got, word_q.pop_front());
        end
      end
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Called in the time step of a rising edge; returns in the step the word is taken.
  task automatic send_byte(input byte_row_t row);
    int gap;
    gap = draw_gap();
    tag_q.push_back(row);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= row.data;
    last_in  <= row.last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (word_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic meter_word_t mk_word(input logic v, input logic [CpBits-1:0] c,
                                          input logic [2:0] n, input logic [1:0] cols,
                                          input logic done, input int wt, input int pt,
                                          input logic tr);
    meter_word_t w;
    w = {v, c, n, cols, done, OutBits'(wt), OutBits'(pt), tr};
    return w;
  endfunction

  function automatic byte_row_t plain_row(input logic [7:0] b, input logic last);
    byte_row_t r;
    r.data  = b;
    r.last  = last;
    r.typed = 1'b0;
    r.word  = '0;
    return r;
  endfunction

  function automatic byte_row_t typed_row(input logic [7:0] b, input logic last,
                                          input meter_word_t w);
    byte_row_t r;
    r       = plain_row(b, last);
    r.typed = 1'b1;
    r.word  = w;
    return r;
  endfunction

  // Continuation bytes occasionally carry wrong top bits, which the block ignores.
  function automatic logic [7:0] tail_byte(input logic [5:0] v);
    logic [1:0] top;
    top = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, v};
  endfunction

  task automatic put_codepoint(input logic [CpBits-1:0] c, input int nbytes);
    case (nbytes)
      1: str_q.push_back({1'b0, c[6:0]});
      2: begin
        str_q.push_back({3'b110, c[10:6]});
        str_q.push_back(tail_byte(c[5:0]));
      end
      3: begin
        str_q.push_back({4'b1110, c[15:12]});
        str_q.push_back(tail_byte(c[11:6]));
        str_q.push_back(tail_byte(c[5:0]));
      end
      default: begin
        str_q.push_back({5'b11110, c[20:18]});
        str_q.push_back(tail_byte(c[17:12]));
        str_q.push_back(tail_byte(c[11:6]));
        str_q.push_back(tail_byte(c[5:0]));
      end
    endcase
  endtask

  function automatic int min_len(input logic [CpBits-1:0] c);
    return (c < 'h80) ? 1 : (c < 'h800) ? 2 : (c < 'h10000) ? 3 : 4;
  endfunction

  function automatic logic [CpBits-1:0] boundary_codepoint();
    logic [CpBits-1:0] lo, hi, c;
    wide_span(int'($urandom_range(0, NumSpans - 1)), lo, hi);
    case ($urandom_range(0, 4))
      0: c = lo - 1'b1;
      1: c = lo;
      2: c = hi;
      3: c = hi + 1'b1;
      default: c = lo + CpBits'($urandom_range(0, hi - lo));
    endcase
    return c;
  endfunction

  task automatic send_random_string();
    int                ncp, kind, nb, cut;
    logic [CpBits-1:0] c;
    str_q.delete();
    ncp = $urandom_range(0, 10);
    for (int i = 0; i < ncp; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        str_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 30) begin
        put_codepoint(CpBits'($urandom_range(0, 'h7F)), 1);
      end else if (kind < 45) begin
        put_codepoint(CpBits'($urandom_range(0, 'h7FF)), 2);
      end else if (kind < 60) begin
        put_codepoint(CpBits'($urandom_range(0, 'hFFFF)), 3);
      end else if (kind < 75) begin
        put_codepoint(CpBits'($urandom_range(0, 'h1FFFFF)), 4);
      end else begin
        c = boundary_codepoint();
        put_codepoint(c, min_len(c));
      end
    end
    // Now and then the string stops inside a multibyte sequence.
    if ($urandom_range(0, 9) == 0) begin
      nb  = $urandom_range(2, 4);
      put_codepoint(CpBits'($urandom_range(0, 'h1FFFFF)), nb);
      cut = $urandom_range(1, nb - 1);
      repeat (cut) void'(str_q.pop_back());
    end
    if (str_q.size() == 0) str_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < str_q.size(); i++) begin
      send_byte(plain_row(str_q[i], i == str_q.size() - 1));
    end
  endtask

  task automatic build_directed();
    // NUL alone: no columns, no padding.
    dir_q.push_back(typed_row(8'h00, 1'b1, mk_word(1, 0, 1, ColsNone, 1, 0, 0, 0)));
    dir_q.push_back(typed_row(8'h41, 1'b0, mk_word(1, 'h41, 1, ColsNarrow, 0, 0, 0, 0)));
    dir_q.push_back(typed_row(8'h7F, 1'b1, mk_word(1, 'h7F, 1, ColsNarrow, 1, 2, 0, 0)));
    dir_q.push_back(plain_row(8'hE4, 1'b0));
    dir_q.push_back(plain_row(8'hB8, 1'b0));
    dir_q.push_back(plain_row(8'h80, 1'b0));
    dir_q.push_back(plain_row(8'hC3, 1'b0));
    dir_q.push_back(plain_row(8'hA9, 1'b1));
    // A stray continuation byte acts as a two-byte lead.
    dir_q.push_back(plain_row(8'h80, 1'b0));
    dir_q.push_back(plain_row(8'hBF, 1'b0));
    // Overlong NUL: two bytes but no padding.
    dir_q.push_back(plain_row(8'hC0, 1'b0));
    dir_q.push_back(plain_row(8'h80, 1'b1));
    // 0xFF is taken as a four-byte lead keeping its low three bits.
    dir_q.push_back(plain_row(8'hFF, 1'b0));
    dir_q.push_back(plain_row(8'hBF, 1'b0));
    dir_q.push_back(plain_row(8'hBF, 1'b0));
    dir_q.push_back(typed_row(8'hBF, 1'b1,
                              mk_word(1, 'h1FFFFF, 4, ColsNarrow, 1, 1, 3, 0)));
    dir_q.push_back(plain_row(8'hF0, 1'b0));
    dir_q.push_back(typed_row(8'h9F, 1'b1, mk_word(0, 0, 0, ColsNone, 1, 0, 0, 1)));
    dir_q.push_back(typed_row(8'hFF, 1'b1, mk_word(0, 0, 0, ColsNone, 1, 0, 0, 1)));
    // U+303F sits inside a wide span but is narrow; U+20000 ends the string.
    dir_q.push_back(plain_row(8'hE3, 1'b0));
    dir_q.push_back(plain_row(8'h80, 1'b0));
    dir_q.push_back(plain_row(8'hBF, 1'b0));
    dir_q.push_back(plain_row(8'hF0, 1'b0));
    dir_q.push_back(plain_row(8'hA0, 1'b0));
    dir_q.push_back(plain_row(8'h80, 1'b0));
    dir_q.push_back(plain_row(8'h80, 1'b1));
  endtask

  initial begin : stimulus
    int start, nstr;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    byte_in  <= '0;
    last_in  <= 1'b0;
    meter_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    build_directed();
    foreach (dir_q[i]) send_byte(dir_q[i]);
    settle();

    start = bytes_sent;
    nstr  = 0;
    while (bytes_sent - start < RandomBytes) begin
      calm = ($urandom_range(0, 5) == 0);
      send_random_string();
      nstr++;
      // Hold the sender back until every word has been delivered.
      if (nstr % 40 == 0) settle();
    end
    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (word_q.size() != 0) report_mismatch("words never delivered", 0, word_q.size());

    if (errors == 0) begin
      $display("PASS utf8_display_width_meter_top");
    end else begin
      $display("FAIL utf8_display_width_meter_top");
    end
    $finish;
  end

endmodule
